>>> src/sbpg_pkg.sv
// Shared types, codes and constants of the seeded buffer pattern generator.
package sbpg_pkg;

    localparam int unsigned LEN_W      = 21;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_RAND = 2'd1;
    localparam logic [1:0] MODE_TEXT = 2'd2;

    localparam logic [1:0] REG_FILL_MODE    = 2'd0;
    localparam logic [1:0] REG_BASE_SEED    = 2'd1;
    localparam logic [1:0] REG_BUFFER_BYTES = 2'd2;
    localparam logic [1:0] REG_PREFIX_BYTES = 2'd3;

    localparam logic [1:0]       RST_FILL_MODE    = MODE_RAND;
    localparam logic [63:0]      RST_BASE_SEED    = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [LEN_W-1:0] RST_BUFFER_BYTES = 21'd65536;
    localparam logic [LEN_W-1:0] RST_PREFIX_BYTES = 21'd65536;

    localparam logic [63:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;

    localparam logic [3:0] TEXT_CHARS_PER_WORD = 4'd10;
    localparam logic [7:0] TEXT_PAD_CHAR       = 8'h41;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_NEXT  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic        func;
        logic [63:0] sequence_req;
        logic [31:0] buffer_index;
    } in_item_t;

    typedef struct packed {
        logic [63:0] chunk_data;
        logic [3:0]  byte_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [63:0]      seed;
        logic [1:0]       mode;
        logic [LEN_W-1:0] size;
        logic [LEN_W-1:0] prefix;
    } cmd_t;

    typedef struct packed {
        logic             done;
        logic [3:0][63:0] words;
    } mix_out_t;

    // base64url alphabet: A-Z, a-z, 0-9, '-', '_'
    function automatic logic [7:0] b64url_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            r = 8'h2d;
        end else begin
            r = 8'h5f;
        end
        return r;
    endfunction

endpackage

>>> src/sbpg_front.sv
// Front end: configuration registers, item classification and start-command setup.
module sbpg_front #(
    parameter int unsigned MAX_BUFFER_BYTES = 1048576
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_wdata,
    input  sbpg_pkg::in_item_t   item,
    output sbpg_pkg::cmd_t       cmd
);

    localparam int unsigned LEN_MAX   = (1 << sbpg_pkg::LEN_W) - 1;
    localparam int unsigned MAX_CLAMP =
        (MAX_BUFFER_BYTES > LEN_MAX) ? LEN_MAX : MAX_BUFFER_BYTES;
    localparam logic [sbpg_pkg::LEN_W-1:0] MAX_LEN = sbpg_pkg::LEN_W'(MAX_CLAMP);

    logic [1:0]                 fill_mode_reg;
    logic [63:0]                base_seed_reg;
    logic [sbpg_pkg::LEN_W-1:0] buffer_bytes_reg;
    logic [sbpg_pkg::LEN_W-1:0] prefix_bytes_reg;
    logic [sbpg_pkg::LEN_W-1:0] size_clamped;
    logic [sbpg_pkg::LEN_W-1:0] prefix_clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_mode_reg    <= sbpg_pkg::RST_FILL_MODE;
            base_seed_reg    <= sbpg_pkg::RST_BASE_SEED;
            buffer_bytes_reg <= sbpg_pkg::RST_BUFFER_BYTES;
            prefix_bytes_reg <= sbpg_pkg::RST_PREFIX_BYTES;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sbpg_pkg::REG_FILL_MODE:    fill_mode_reg    <= cfg_wdata[1:0];
                sbpg_pkg::REG_BASE_SEED:    base_seed_reg    <= cfg_wdata;
                sbpg_pkg::REG_BUFFER_BYTES: buffer_bytes_reg <= cfg_wdata[sbpg_pkg::LEN_W-1:0];
                sbpg_pkg::REG_PREFIX_BYTES: prefix_bytes_reg <= cfg_wdata[sbpg_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp size to 1..MAX and prefix to 1..size
    always_comb begin
        if (buffer_bytes_reg == '0) begin
            size_clamped = sbpg_pkg::LEN_W'(1);
        end else if (buffer_bytes_reg > MAX_LEN) begin
            size_clamped = MAX_LEN;
        end else begin
            size_clamped = buffer_bytes_reg;
        end
        if (prefix_bytes_reg == '0) begin
            prefix_clamped = sbpg_pkg::LEN_W'(1);
        end else if (prefix_bytes_reg > size_clamped) begin
            prefix_clamped = size_clamped;
        end else begin
            prefix_clamped = prefix_bytes_reg;
        end
    end

    always_comb begin
        cmd.kind   = item.func ? sbpg_pkg::CMD_NEXT : sbpg_pkg::CMD_START;
        cmd.seed   = base_seed_reg ^ item.sequence_req ^ {item.buffer_index, 32'h0};
        cmd.mode   = fill_mode_reg;
        cmd.size   = size_clamped;
        cmd.prefix = prefix_clamped;
    end

endmodule

>>> src/sbpg_cmd_fifo.sv
// Short command queue between front end and back end.
module sbpg_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sbpg_pkg::cmd_t push_cmd,
    input  logic           pop,
    output sbpg_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int unsigned PTR_W = (sbpg_pkg::FIFO_DEPTH > 1) ? $clog2(sbpg_pkg::FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(sbpg_pkg::FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(sbpg_pkg::FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(sbpg_pkg::FIFO_DEPTH - 1);

    sbpg_pkg::cmd_t   entry_reg [sbpg_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == DEPTH_CNT);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> !full)
        else $error("command queue overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command queue underflow");

endmodule

>>> src/sbpg_mix.sv
// Seeding unit: four chained splitmix64 rounds on one shared 32x32 multiplier.
module sbpg_mix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [63:0]        seed,
    output sbpg_pkg::mix_out_t mix_o
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_PRE  = 5'b00010,
        M_MUL  = 5'b00100,
        M_MID  = 5'b01000,
        M_POST = 5'b10000
    } mix_state_t;

    mix_state_t       state_reg;
    logic [63:0]      v_reg;
    logic [63:0]      acc_reg;
    logic [1:0]       ph_reg;
    logic             second_reg;
    logic [1:0]       round_reg;
    logic             done_reg;
    logic [3:0][63:0] words_reg;

    logic [63:0] mul_k;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [63:0] pre_sum;
    logic [63:0] post_word;

    assign mul_k = second_reg ? sbpg_pkg::MIX_MUL_B : sbpg_pkg::MIX_MUL_A;

    // Low 64 bits of v * k from three partial products
    always_comb begin
        case (ph_reg)
            2'd0:    begin op_a = v_reg[31:0];  op_b = mul_k[31:0];  end
            2'd1:    begin op_a = v_reg[31:0];  op_b = mul_k[63:32]; end
            default: begin op_a = v_reg[63:32]; op_b = mul_k[31:0];  end
        endcase
        prod = {32'h0, op_a} * {32'h0, op_b};
    end

    assign pre_sum   = v_reg + sbpg_pkg::MIX_GOLDEN;
    assign post_word = v_reg ^ (v_reg >> 31);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == M_POST) && (round_reg == 2'd3);
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        state_reg <= M_PRE;
                    end
                end
                M_PRE:  state_reg <= M_MUL;
                M_MUL: begin
                    if (ph_reg == 2'd2) begin
                        state_reg <= second_reg ? M_POST : M_MID;
                    end
                end
                M_MID:  state_reg <= M_MUL;
                M_POST: begin
                    if (round_reg == 2'd3) begin
                        state_reg <= M_IDLE;
                    end else begin
                        state_reg <= M_PRE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            M_IDLE: begin
                v_reg     <= seed;
                round_reg <= 2'd0;
            end
            M_PRE: begin
                v_reg      <= pre_sum ^ (pre_sum >> 30);
                second_reg <= 1'b0;
                ph_reg     <= 2'd0;
            end
            M_MUL: begin
                if (ph_reg == 2'd0) begin
                    acc_reg <= prod;
                    ph_reg  <= 2'd1;
                end else if (ph_reg == 2'd1) begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                    ph_reg         <= 2'd2;
                end else begin
                    v_reg <= {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                end
            end
            M_MID: begin
                v_reg      <= v_reg ^ (v_reg >> 27);
                second_reg <= 1'b1;
                ph_reg     <= 2'd0;
            end
            M_POST: begin
                // Shift in so the first round ends up in word 0
                v_reg     <= post_word;
                words_reg <= {post_word, words_reg[3:1]};
                round_reg <= round_reg + 2'd1;
            end
            default: ;
        endcase
    end

    assign mix_o.done  = done_reg;
    assign mix_o.words = words_reg;

endmodule

>>> src/sbpg_back.sv
// Back end: seeding control, xoshiro256++ state and chunk assembly into the output register.
module sbpg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  sbpg_pkg::cmd_t     head,
    input  logic               empty,
    output logic               pop,
    output logic               mix_start,
    output logic [63:0]        mix_seed,
    input  sbpg_pkg::mix_out_t mix_i,
    output logic               m_valid,
    input  logic               m_ready,
    output sbpg_pkg::out_item_t m_data
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_SEED = 3'b010,
        B_EMIT = 3'b100
    } back_state_t;

    localparam int unsigned LW = sbpg_pkg::LEN_W;

    back_state_t          state_reg;
    logic [3:0][63:0]     st_reg;
    logic [63:0]          word_reg;
    logic [LW-1:0]        offset_reg;
    logic [63:0]          text_reg;
    logic [3:0]           cl_reg;
    logic                 buf_active_reg;
    logic [1:0]           mode_reg;
    logic [LW-1:0]        size_reg;
    logic [LW-1:0]        prefix_reg;
    logic                 out_valid_reg;
    sbpg_pkg::out_item_t  out_reg;

    logic [63:0]          res_word;
    logic [3:0][63:0]     st_adv;
    logic [LW-1:0]        remain;
    logic [3:0]           count;
    logic                 fin;
    logic [LW-1:0]        pre_left;
    logic [3:0]           m;
    logic                 need_word;
    logic                 need_text;
    logic [3:0]           k_new;
    logic [63:0]          data;
    logic [63:0]          text_next;
    logic [3:0]           cl_next;
    logic                 out_free;
    logic                 load_out;

    // xoshiro256++ output and state step
    always_comb begin
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] s2a;
        logic [63:0] s3a;
        sum      = st_reg[0] + st_reg[3];
        res_word = {sum[40:0], sum[63:41]} + st_reg[0];
        t        = st_reg[1] << 17;
        s2a      = st_reg[2] ^ st_reg[0];
        s3a      = st_reg[3] ^ st_reg[1];
        st_adv[1] = st_reg[1] ^ s2a;
        st_adv[0] = st_reg[0] ^ s3a;
        st_adv[2] = s2a ^ t;
        st_adv[3] = {s3a[18:0], s3a[63:19]};
    end

    // Chunk assembly from the latched word
    always_comb begin
        logic [3:0] kk;
        logic [3:0] diff;
        logic [6:0] sh;
        logic [5:0] idx;
        remain   = size_reg - offset_reg;
        count    = (remain < LW'(8)) ? remain[3:0] : 4'd8;
        fin      = (remain <= LW'(8));
        pre_left = (prefix_reg > offset_reg) ? prefix_reg - offset_reg : '0;
        m        = (pre_left < LW'(count)) ? pre_left[3:0] : count;
        need_text = (mode_reg == sbpg_pkg::MODE_TEXT) && (m > cl_reg);
        need_word = ((mode_reg == sbpg_pkg::MODE_RAND) && (m != 4'd0)) || need_text;
        k_new     = m - cl_reg;
        data      = '0;
        for (int k = 0; k < 8; k++) begin
            kk   = 4'(k);
            diff = kk - cl_reg;
            sh   = 7'(diff) * 7'd6;
            idx  = '0;
            if (mode_reg == sbpg_pkg::MODE_RAND) begin
                if (kk < m) begin
                    data[8*k +: 8] = word_reg[8*k +: 8];
                end
            end else if (mode_reg == sbpg_pkg::MODE_TEXT) begin
                if (kk < m) begin
                    if (kk < cl_reg) begin
                        idx = text_reg[6*k +: 6];
                    end else begin
                        idx = 6'(word_reg >> sh);
                    end
                    data[8*k +: 8] = sbpg_pkg::b64url_char(idx);
                end else if (kk < count) begin
                    data[8*k +: 8] = sbpg_pkg::TEXT_PAD_CHAR;
                end
            end
        end
        if (need_text) begin
            text_next = word_reg >> (7'(k_new) * 7'd6);
            cl_next   = sbpg_pkg::TEXT_CHARS_PER_WORD - k_new;
        end else begin
            text_next = text_reg >> (7'(m) * 7'd6);
            cl_next   = cl_reg - m;
        end
    end

    assign out_free  = !out_valid_reg || m_ready;
    assign load_out  = (state_reg == B_EMIT) && out_free;
    assign pop       = (state_reg == B_IDLE) && !empty;
    assign mix_start = pop && (head.kind == sbpg_pkg::CMD_START);
    assign mix_seed  = head.seed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            buf_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            offset_reg     <= '0;
            cl_reg         <= '0;
            text_reg       <= '0;
            st_reg         <= '0;
            mode_reg       <= sbpg_pkg::MODE_ZERO;
            size_reg       <= '0;
            prefix_reg     <= '0;
        end else begin
            // Hold the result until it is taken
            out_valid_reg <= load_out || (out_valid_reg && !m_ready);
            unique case (state_reg)
                B_IDLE: begin
                    if (pop) begin
                        if (head.kind == sbpg_pkg::CMD_START) begin
                            // Abandon any open buffer
                            buf_active_reg <= 1'b0;
                            offset_reg     <= '0;
                            mode_reg       <= head.mode;
                            size_reg       <= head.size;
                            prefix_reg     <= head.prefix;
                            state_reg      <= B_SEED;
                        end else if (buf_active_reg) begin
                            state_reg <= B_EMIT;
                        end
                    end
                end
                B_SEED: begin
                    if (mix_i.done) begin
                        st_reg         <= mix_i.words;
                        text_reg       <= '0;
                        cl_reg         <= '0;
                        buf_active_reg <= 1'b1;
                        state_reg      <= B_IDLE;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        if (need_word) begin
                            st_reg <= st_adv;
                        end
                        if (mode_reg == sbpg_pkg::MODE_TEXT) begin
                            text_reg <= text_next;
                            cl_reg   <= cl_next;
                        end
                        if (fin) begin
                            buf_active_reg <= 1'b0;
                            offset_reg     <= size_reg;
                        end else begin
                            offset_reg <= offset_reg + LW'(count);
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            word_reg <= res_word;
        end
        if (load_out) begin
            out_reg.chunk_data <= data;
            out_reg.byte_count <= count;
            out_reg.last       <= fin;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_offset_in_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_active_reg |-> (offset_reg < size_reg))
        else $error("byte offset ran past buffer end while active");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && fin) |=> !buf_active_reg)
        else $error("buffer still active after final chunk");

    a_seed_inactive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SEED) |-> !buf_active_reg)
        else $error("buffer active while seeding");

endmodule

>>> src/seeded_buffer_pattern_generator.sv
// Top level of the seeded buffer pattern generator.
//
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------------
//  input   | s_valid, s_ready, s_data       | func, sequence_req, buffer_index
//  result  | m_valid, m_ready, m_data       | chunk_data, byte_count, last
//  config  | cfg_wr_en, cfg_index, cfg_wdata| fill_mode, base_seed, sizes
//
// In the back end a chunk request first latches the xoshiro256++ word on its pop, then
// assembles the chunk into the output register once that register is free.
// A start runs four splitmix64 rounds, each with two 64-bit multiplies done as three
// passes through one 32x32 multiplier.
// Input items enter a two-entry command queue, so s_ready drops only when it is full.
// Reset is synchronous on aresetn and needs no clearing pass.
module seeded_buffer_pattern_generator #(
    parameter int unsigned MAX_BUFFER_BYTES = 1048576
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbpg_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sbpg_pkg::out_item_t m_data
);

    sbpg_pkg::cmd_t     front_cmd;
    sbpg_pkg::cmd_t     head;
    sbpg_pkg::mix_out_t mix_out;
    logic               q_empty;
    logic               q_full;
    logic               q_pop;
    logic               mix_start;
    logic [63:0]        mix_seed;

    assign s_ready = !q_full;

    sbpg_front #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (s_data),
        .cmd       (front_cmd)
    );

    sbpg_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid && s_ready),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sbpg_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .seed    (mix_seed),
        .mix_o   (mix_out)
    );

    sbpg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .empty     (q_empty),
        .pop       (q_pop),
        .mix_start (mix_start),
        .mix_seed  (mix_seed),
        .mix_i     (mix_out),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> verif/tb_seeded_buffer_pattern_generator.sv
// Self-checking testbench for the seeded buffer pattern generator.
`timescale 1ns / 1ps

module tb_seeded_buffer_pattern_generator;

    localparam int unsigned MAX_BYTES      = 1048576;
    localparam int unsigned RANDOM_ITEMS   = 1500;
    localparam int unsigned SETTLE_CYCLES  = 160;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_RUN_CHUNKS = 24;
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;

    // base64url alphabet, first character in the top byte
    localparam logic [511:0] B64_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_TYPED
    } exp_kind_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SEND
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [1:0]          reg_idx;
        logic [63:0]         reg_val;
        sbpg_pkg::in_item_t  item;
        exp_kind_t           exp;
        sbpg_pkg::out_item_t want;
    } plan_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [63:0]         cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    sbpg_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    sbpg_pkg::out_item_t m_data;

    seeded_buffer_pattern_generator #(
        .MAX_BUFFER_BYTES(MAX_BYTES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // generator state as predicted
    logic [1:0]                 reg_mode;
    logic [63:0]                reg_seed;
    logic [sbpg_pkg::LEN_W-1:0] reg_size;
    logic [sbpg_pkg::LEN_W-1:0] reg_prefix;
    logic [63:0]                xs [4];
    logic [1:0]                 cur_mode;
    int unsigned                cur_size;
    int unsigned                cur_prefix;
    int unsigned                offs;
    logic [63:0]                text_bits;
    int unsigned                text_left;
    bit                         in_buffer;

    sbpg_pkg::out_item_t pending_chunks [$];
    plan_row_t           plan [$];
    int unsigned         items_sent;
    int unsigned         errors;
    int unsigned         quiet_cycles;
    bit                  calm;
    bit                  hold_req;

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        v = v + sbpg_pkg::MIX_GOLDEN;
        v = (v ^ (v >> 30)) * sbpg_pkg::MIX_MUL_A;
        v = (v ^ (v >> 27)) * sbpg_pkg::MIX_MUL_B;
        return v ^ (v >> 31);
    endfunction

    function automatic logic [63:0] xoshiro_step();
        logic [63:0] sum;
        logic [63:0] res;
        logic [63:0] t;
        sum = xs[0] + xs[3];
        res = {sum[40:0], sum[63:41]} + xs[0];
        t = xs[1] << 17;
        xs[2] = xs[2] ^ xs[0];
        xs[3] = xs[3] ^ xs[1];
        xs[1] = xs[1] ^ xs[2];
        xs[0] = xs[0] ^ xs[3];
        xs[2] = xs[2] ^ t;
        xs[3] = {xs[3][18:0], xs[3][63:19]};
        return res;
    endfunction

    function automatic bit predict_chunk(input sbpg_pkg::in_item_t it,
                                         output sbpg_pkg::out_item_t res);
        logic [63:0] seed;
        logic [63:0] w;
        logic [63:0] data;
        logic [7:0]  ch;
        int unsigned remain;
        int unsigned count;
        res = '0;
        if (it.func == sbpg_pkg::CMD_START) begin
            seed = reg_seed ^ it.sequence_req ^ {it.buffer_index, 32'h0};
            for (int i = 0; i < 4; i++) begin
                seed = splitmix(seed);
                xs[i] = seed;
            end
            cur_size = 32'(reg_size);
            if (cur_size < 1) cur_size = 1;
            if (cur_size > MAX_BYTES) cur_size = MAX_BYTES;
            cur_prefix = 32'(reg_prefix);
            if (cur_prefix < 1) cur_prefix = 1;
            if (cur_prefix > cur_size) cur_prefix = cur_size;
            cur_mode = reg_mode;
            offs = 0;
            text_bits = '0;
            text_left = 0;
            in_buffer = 1'b1;
            return 1'b0;
        end
        if (!in_buffer) return 1'b0;

        remain = cur_size - offs;
        count = (remain < 8) ? remain : 8;
        data = '0;
        if (cur_mode == sbpg_pkg::MODE_RAND) begin
            if (offs < cur_prefix) begin
                w = xoshiro_step();
                for (int k = 0; k < count; k++) begin
                    if (offs + k < cur_prefix) data[8*k +: 8] = w[8*k +: 8];
                end
            end
        end else if (cur_mode == sbpg_pkg::MODE_TEXT) begin
            for (int k = 0; k < count; k++) begin
                if (offs + k < cur_prefix) begin
                    if (text_left == 0) begin
                        text_bits = xoshiro_step();
                        text_left = 32'(sbpg_pkg::TEXT_CHARS_PER_WORD);
                    end
                    ch = B64_CHARS[8*(63 - int'(text_bits[5:0])) +: 8];
                    text_bits = text_bits >> 6;
                    text_left--;
                end else begin
                    ch = sbpg_pkg::TEXT_PAD_CHAR;
                end
                data[8*k +: 8] = ch;
            end
        end
        res.chunk_data = data;
        res.byte_count = count[3:0];
        res.last = (remain <= 8);
        if (remain <= 8) begin
            in_buffer = 1'b0;
            offs = cur_size;
        end else begin
            offs = offs + count;
        end
        return 1'b1;
    endfunction

    function automatic sbpg_pkg::in_item_t make_item(input sbpg_pkg::cmd_kind_t f);
        sbpg_pkg::in_item_t it;
        it.func = f;
        it.sequence_req = {$urandom, $urandom};
        it.buffer_index = $urandom;
        return it;
    endfunction

    function automatic void plan_write(input logic [1:0] idx, input logic [63:0] val);
        plan_row_t r;
        r = '{ROW_WRITE, idx, val, '0, EXP_NONE, '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_start(input logic [63:0] sq, input logic [31:0] bi);
        plan_row_t          r;
        sbpg_pkg::in_item_t it;
        it.func = sbpg_pkg::CMD_START;
        it.sequence_req = sq;
        it.buffer_index = bi;
        r = '{ROW_SEND, sbpg_pkg::REG_FILL_MODE, 64'd0, it, EXP_NONE, '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_next(input exp_kind_t e, input logic [63:0] d,
                                      input logic [3:0] c, input logic l);
        plan_row_t           r;
        sbpg_pkg::out_item_t w;
        w.chunk_data = d;
        w.byte_count = c;
        w.last = l;
        r = '{ROW_SEND, sbpg_pkg::REG_FILL_MODE, 64'd0, make_item(sbpg_pkg::CMD_NEXT), e, w};
        plan.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ERROR %s: got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        s_valid = 1'b0;
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            sbpg_pkg::REG_FILL_MODE:    reg_mode = val[1:0];
            sbpg_pkg::REG_BASE_SEED:    reg_seed = val;
            sbpg_pkg::REG_BUFFER_BYTES: reg_size = val[sbpg_pkg::LEN_W-1:0];
            sbpg_pkg::REG_PREFIX_BYTES: reg_prefix = val[sbpg_pkg::LEN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input sbpg_pkg::in_item_t it, input exp_kind_t e,
                             input sbpg_pkg::out_item_t want);
        sbpg_pkg::out_item_t got;
        bit                  made;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        do @(posedge aclk); while (!s_ready);
        made = predict_chunk(it, got);
        if (e == EXP_TYPED) pending_chunks.push_back(want);
        else if (made && e == EXP_MODEL) pending_chunks.push_back(got);
        if (it.func == sbpg_pkg::CMD_START || made) items_sent++;
    endtask

    // stop offering, let every expected chunk arrive, then wait out queued seedings
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_chunks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver: short stall bursts, one long hold-off on request
    initial begin
        int unsigned stall_left;
        bit          stall;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                stall = 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                stall = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                stall = 1'b1;
            end else begin
                stall = 1'b0;
            end
            m_ready = !stall;
        end
    end

    always @(posedge aclk) begin
        sbpg_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chunks.size() == 0) begin
                report_mismatch("chunk with none pending", m_data.chunk_data, 64'd0);
            end else begin
                want = pending_chunks.pop_front();
                if (m_data.chunk_data !== want.chunk_data)
                    report_mismatch("chunk_data", m_data.chunk_data, want.chunk_data);
                if (m_data.byte_count !== want.byte_count)
                    report_mismatch("byte_count", 64'(m_data.byte_count),
                                    64'(want.byte_count));
                if (m_data.last !== want.last)
                    report_mismatch("last", 64'(m_data.last), 64'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("seeded_buffer_pattern_generator: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sbpg_pkg::in_item_t         it;
        sbpg_pkg::out_item_t        none;
        bit                         dirty;
        bit                         junk;
        int unsigned                n;
        int unsigned                phase_end;
        logic [1:0]                 mode;
        logic [sbpg_pkg::LEN_W-1:0] sz;
        logic [sbpg_pkg::LEN_W-1:0] pre;
        logic [63:0]                v;
        logic [63:0]                seed_v;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = sbpg_pkg::REG_FILL_MODE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        errors = 0;
        items_sent = 0;
        quiet_cycles = 0;
        none = '0;
        dirty = 1'b0;

        reg_mode = sbpg_pkg::RST_FILL_MODE;
        reg_seed = sbpg_pkg::RST_BASE_SEED;
        reg_size = sbpg_pkg::RST_BUFFER_BYTES;
        reg_prefix = sbpg_pkg::RST_PREFIX_BYTES;
        for (int i = 0; i < 4; i++) xs[i] = '0;
        cur_mode = sbpg_pkg::MODE_ZERO;
        cur_size = 0;
        cur_prefix = 0;
        offs = 0;
        text_bits = '0;
        text_left = 0;
        in_buffer = 1'b0;

        // next with no buffer open
        plan_next(EXP_NONE, 64'd0, 4'd0, 1'b0);
        // zero fill, 20 bytes, then one request past the end
        plan_write(sbpg_pkg::REG_FILL_MODE, sbpg_pkg::MODE_ZERO);
        plan_write(sbpg_pkg::REG_BUFFER_BYTES, 64'd20);
        plan_start(64'h1234_5678_9abc_def0, 32'h0000_0001);
        plan_next(EXP_TYPED, 64'd0, 4'd8, 1'b0);
        plan_next(EXP_TYPED, 64'd0, 4'd8, 1'b0);
        plan_next(EXP_TYPED, 64'd0, 4'd4, 1'b1);
        plan_next(EXP_NONE, 64'd0, 4'd0, 1'b0);
        // size zero counts as one byte, unused mode gives zeros
        plan_write(sbpg_pkg::REG_BUFFER_BYTES, 64'd0);
        plan_write(sbpg_pkg::REG_FILL_MODE, MODE_UNUSED);
        plan_start(64'd7, 32'd7);
        plan_next(EXP_TYPED, 64'd0, 4'd1, 1'b1);
        // random words, one-byte prefix, zero seed
        plan_write(sbpg_pkg::REG_FILL_MODE, sbpg_pkg::MODE_RAND);
        plan_write(sbpg_pkg::REG_BUFFER_BYTES, 64'd16);
        plan_write(sbpg_pkg::REG_PREFIX_BYTES, 64'd1);
        plan_write(sbpg_pkg::REG_BASE_SEED, 64'd0);
        plan_start(64'd0, 32'd0);
        plan_next(EXP_MODEL, 64'd0, 4'd0, 1'b0);
        plan_next(EXP_TYPED, 64'd0, 4'd8, 1'b1);
        // text with one-byte prefix pads with 'A'
        plan_write(sbpg_pkg::REG_FILL_MODE, sbpg_pkg::MODE_TEXT);
        plan_start('1, '1);
        plan_next(EXP_MODEL, 64'd0, 4'd0, 1'b0);
        plan_next(EXP_TYPED, 64'h4141_4141_4141_4141, 4'd8, 1'b1);
        // oversize buffer, zero prefix, restart in the middle of a buffer
        plan_write(sbpg_pkg::REG_BUFFER_BYTES, '1);
        plan_write(sbpg_pkg::REG_PREFIX_BYTES, 64'd0);
        plan_write(sbpg_pkg::REG_BASE_SEED, '1);
        plan_write(sbpg_pkg::REG_FILL_MODE, sbpg_pkg::MODE_RAND);
        plan_start(64'h8000_0000_0000_0000, 32'h8000_0000);
        plan_next(EXP_MODEL, 64'd0, 4'd0, 1'b0);
        plan_next(EXP_TYPED, 64'd0, 4'd8, 1'b0);
        plan_start(64'h0000_0000_0000_0001, 32'h0000_0001);
        plan_next(EXP_MODEL, 64'd0, 4'd0, 1'b0);
        // text across a word boundary, prefix above the buffer size
        plan_write(sbpg_pkg::REG_FILL_MODE, sbpg_pkg::MODE_TEXT);
        plan_write(sbpg_pkg::REG_PREFIX_BYTES, 64'h1F_FFFF);
        plan_write(sbpg_pkg::REG_BUFFER_BYTES, 64'd25);
        plan_start(64'h0123_4567_89ab_cdef, 32'hdead_beef);
        repeat (4) plan_next(EXP_MODEL, 64'd0, 4'd0, 1'b0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (dirty) begin
                    drain();
                    dirty = 1'b0;
                end
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, plan[i].exp, plan[i].want);
                dirty = 1'b1;
            end
        end

        // long output hold-off while requests keep coming, so the input backs up
        drain();
        write_reg(sbpg_pkg::REG_FILL_MODE, sbpg_pkg::MODE_RAND);
        write_reg(sbpg_pkg::REG_BUFFER_BYTES, 64'd4096);
        write_reg(sbpg_pkg::REG_PREFIX_BYTES, 64'd4096);
        send_item(make_item(sbpg_pkg::CMD_START), EXP_MODEL, none);
        hold_req = 1'b1;
        repeat (40) send_item(make_item(sbpg_pkg::CMD_NEXT), EXP_MODEL, none);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            drain();
            calm = (items_sent + 150 >= RANDOM_ITEMS) || ($urandom_range(0, 3) == 0);

            n = $urandom_range(0, 7);
            mode = (n == 0) ? sbpg_pkg::MODE_ZERO : (n == 1) ? MODE_UNUSED :
                   (n < 5) ? sbpg_pkg::MODE_RAND : sbpg_pkg::MODE_TEXT;
            case ($urandom_range(0, 7))
                0: seed_v = '0;
                1: seed_v = '1;
                default: seed_v = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 15))
                0: sz = '0;
                1: sz = sbpg_pkg::LEN_W'(MAX_BYTES);
                2: sz = '1;
                3: sz = sbpg_pkg::LEN_W'($urandom_range(1, 8));
                default: sz = sbpg_pkg::LEN_W'($urandom_range(1, 48));
            endcase
            case ($urandom_range(0, 7))
                0: pre = '0;
                1: pre = '1;
                2: pre = sbpg_pkg::LEN_W'(1);
                default: pre = sbpg_pkg::LEN_W'($urandom_range(1, 56));
            endcase

            v = {$urandom, $urandom};
            junk = ($urandom_range(0, 3) == 0);
            write_reg(sbpg_pkg::REG_FILL_MODE, junk ? {v[63:2], mode} : {62'd0, mode});
            write_reg(sbpg_pkg::REG_BASE_SEED, seed_v);
            write_reg(sbpg_pkg::REG_BUFFER_BYTES,
                      junk ? {v[63:sbpg_pkg::LEN_W], sz} : {43'd0, sz});
            write_reg(sbpg_pkg::REG_PREFIX_BYTES,
                      junk ? {v[sbpg_pkg::LEN_W-1:0], v[63:2*sbpg_pkg::LEN_W], pre}
                           : {43'd0, pre});

            phase_end = items_sent + 120;
            while (items_sent < phase_end && items_sent < RANDOM_ITEMS) begin
                if ($urandom_range(0, 6) == 0) begin
                    // noise: stray requests and restarts
                    repeat ($urandom_range(1, 4)) begin
                        it = make_item($urandom_range(0, 1) ? sbpg_pkg::CMD_NEXT
                                                            : sbpg_pkg::CMD_START);
                        send_item(it, EXP_MODEL, none);
                    end
                end else begin
                    send_item(make_item(sbpg_pkg::CMD_START), EXP_MODEL, none);
                    n = (cur_size + 7) / 8;
                    if (n > MAX_RUN_CHUNKS) n = MAX_RUN_CHUNKS;
                    // cut some buffers short, overrun others
                    if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
                    else n = n + $urandom_range(0, 2);
                    repeat (n) send_item(make_item(sbpg_pkg::CMD_NEXT), EXP_MODEL, none);
                end
                if ($urandom_range(0, 24) == 0) drain();
            end
        end

        calm = 1'b1;
        drain();
        if (errors == 0) begin
            $display("seeded_buffer_pattern_generator: match");
        end else begin
            $display("seeded_buffer_pattern_generator: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
src/sbpg_pkg.sv
src/sbpg_front.sv
src/sbpg_cmd_fifo.sv
src/sbpg_mix.sv
src/sbpg_back.sv
src/seeded_buffer_pattern_generator.sv
verif/tb_seeded_buffer_pattern_generator.sv
